/* rtl/core/acfd_pkg.sv */
// Shared constants and codes for the ASCII command frame decoder.
`default_nettype none
package acfd_pkg;

  // Default payload store depth
  localparam int unsigned MaxPayloadDef = 32;

  // Register indexes on the configuration port
  localparam logic [2:0] RegStartChar = 3'd0;
  localparam logic [2:0] RegEndChar   = 3'd1;
  localparam logic [2:0] RegSepChar   = 3'd2;
  localparam logic [2:0] RegMinPay    = 3'd3;
  localparam logic [2:0] RegAddrDig   = 3'd4;

  // Register reset values
  localparam logic [7:0] StartCharRst = 8'h5B;
  localparam logic [7:0] EndCharRst   = 8'h5D;
  localparam logic [7:0] SepCharRst   = 8'h3A;
  localparam logic [5:0] MinPayRst    = 6'd1;
  localparam logic [3:0] AddrDigRst   = 4'd2;

  // Framing characters
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  // Status codes
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatFrame  = 2'd1;
  localparam logic [1:0] StatFields = 2'd2;

  // Command codes
  localparam logic [2:0] CmdLed     = 3'd0;
  localparam logic [2:0] CmdAn      = 3'd1;
  localparam logic [2:0] CmdPwm     = 3'd2;
  localparam logic [2:0] CmdAcc     = 3'd3;
  localparam logic [2:0] CmdTou     = 3'd4;
  localparam logic [2:0] CmdUnknown = 3'd5;

endpackage
`default_nettype wire

/* rtl/core/ascii_command_frame_decoder_top.sv */
// Top level of the ASCII command frame decoder: framing, payload store and field decode.
// Framing bytes are taken one a cycle while the output is free; a result for a framing error is ready the cycle after.
// After the LF the stored payload is walked one byte a cycle out of the payload RAM:
// a decoded result is registered once the last byte is parsed and the output is free.
// No byte is taken during that walk; otherwise one byte a cycle while the output is free.
// Reset (rst_ni low, asynchronous) returns to idle and restores the register defaults.
`default_nettype none
module ascii_command_frame_decoder_top
  import acfd_pkg::*;
#(
  parameter int unsigned MaxPayload = MaxPayloadDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // received bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata    // [1:0] status, [4:2] command,
                                           // [36:5] address, [68:37] value, rest zero
);

  localparam int unsigned AW = $clog2(MaxPayload);
  localparam int unsigned CW = $clog2(MaxPayload + 1);

  typedef enum logic [2:0] {
    StIdle, StPay, StWantCr, StWantLf, StDec
  } state_e;

  typedef enum logic [1:0] {
    PsSpace, PsDigit, PsDone
  } parse_e;

  // configuration registers
  logic [7:0] start_q, end_q, sep_q;
  logic [5:0] minpay_q;
  logic [3:0] adig_q;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          hsep_q, hsep_d;
  logic          dfound_q, dfound_d;
  logic [CW-1:0] dpos_q, dpos_d;
  logic [CW-1:0] walk_q, walk_d;
  logic          pv_q, pv_d;
  logic [CW-1:0] pidx_q, pidx_d;
  logic [1:0]    cur_q, cur_d;
  parse_e        ps_q, ps_d;
  logic          neg_q, neg_d;
  logic [31:0]   acc_q, acc_d;
  logic [2:0]    nlen_q, nlen_d;
  logic [7:0]    nc0_q, nc0_d, nc1_q, nc1_d, nc2_q, nc2_d;
  logic [2:0]    cmd_q, cmd_d;
  logic [31:0]   adr_q, adr_d, val_q, val_d;
  logic          mv_q, mv_d;
  logic [1:0]    os_q, os_d;
  logic [2:0]    oc_q, oc_d;
  logic [31:0]   oa_q, oa_d, ov_q, ov_d;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          in_acc, out_free;
  logic [7:0]    rb;

  // payload store
  acfd_ram #(
    .Width (8),
    .Depth (MaxPayload)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  // command name match over the first three name characters
  function automatic logic [2:0] match_name(input logic [2:0] len, input logic [7:0] c0,
                                            input logic [7:0] c1, input logic [7:0] c2);
    logic [2:0] r;
    r = CmdUnknown;
    if (len == 3'd3) begin
      if (c0 == 8'h4C && c1 == 8'h45 && c2 == 8'h44) r = CmdLed;
      else if (c0 == 8'h50 && c1 == 8'h57 && c2 == 8'h4D) r = CmdPwm;
      else if (c0 == 8'h41 && c1 == 8'h43 && c2 == 8'h43) r = CmdAcc;
      else if (c0 == 8'h54 && c1 == 8'h4F && c2 == 8'h55) r = CmdTou;
    end else if (len == 3'd2) begin
      if (c0 == 8'h41 && c1 == 8'h4E) r = CmdAn;
    end
    return r;
  endfunction

  assign out_free      = !mv_q || m_axis_tready;
  assign s_axis_tready = (state_q != StDec) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rb            = s_axis_tdata;

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {3'b000, ov_q, oa_q, oc_q, os_q};

  // next-state logic
  always_comb begin
    logic [CW-1:0] kk;
    logic [CW:0]   ksum;
    logic          nf3;
    logic [1:0]    fsel;
    logic [31:0]   pres;
    logic [2:0]    nm;
    logic [7:0]    b;
    logic          close;
    logic          fresh;
    logic [1:0]    tgt;
    parse_e        ps_b;
    logic          neg_b;
    logic [31:0]   acc_b;
    logic [2:0]    nlen_b;
    logic          err;

    state_d  = state_q;
    cnt_d    = cnt_q;
    hsep_d   = hsep_q;
    dfound_d = dfound_q;
    dpos_d   = dpos_q;
    walk_d   = walk_q;
    pv_d     = 1'b0;
    pidx_d   = pidx_q;
    cur_d    = cur_q;
    ps_d     = ps_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    nlen_d   = nlen_q;
    nc0_d    = nc0_q;
    nc1_d    = nc1_q;
    nc2_d    = nc2_q;
    cmd_d    = cmd_q;
    adr_d    = adr_q;
    val_d    = val_q;
    mv_d     = mv_q && !m_axis_tready;
    os_d     = os_q;
    oc_d     = oc_q;
    oa_d     = oa_q;
    ov_d     = ov_q;
    ram_we   = 1'b0;
    ram_raddr = walk_q[AW-1:0];
    err      = 1'b0;

    // field boundaries when there is no separator
    kk   = dfound_q ? dpos_q : cnt_q;
    ksum = {1'b0, kk} + (CW+1)'(adig_q);
    nf3  = ksum < {1'b0, cnt_q};
    b    = ram_rdata;
    if ({1'b0, pidx_q} < {1'b0, kk}) fsel = 2'd0;
    else if (nf3 && ({1'b0, pidx_q} >= ksum)) fsel = 2'd2;
    else fsel = 2'd1;

    // value and name of the field now open
    pres = neg_q ? (32'd0 - acc_q) : acc_q;
    nm   = match_name(nlen_q, nc0_q, nc1_q, nc2_q);

    close = 1'b0;
    fresh = 1'b0;
    tgt   = cur_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc && rb == start_q) begin
          cnt_d    = '0;
          hsep_d   = 1'b0;
          dfound_d = 1'b0;
          state_d  = StPay;
        end
      end
      StPay: begin
        if (in_acc) begin
          priority if (rb == start_q || 32'(cnt_q) >= MaxPayload) begin
            err = 1'b1;
          end else if (rb == end_q) begin
            if (32'(cnt_q) >= 32'(minpay_q)) state_d = StWantCr;
            else err = 1'b1;
          end else begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
            if (rb == sep_q) hsep_d = 1'b1;
            if (is_dig(rb) && !dfound_q) begin
              dfound_d = 1'b1;
              dpos_d   = cnt_q;
            end
          end
        end
      end
      StWantCr: begin
        if (in_acc) begin
          if (rb == ChCr) state_d = StWantLf;
          else err = 1'b1;
        end
      end
      StWantLf: begin
        if (in_acc) begin
          if (rb == ChLf) begin
            state_d = StDec;
            walk_d  = '0;
            cur_d   = 2'd0;
            ps_d    = PsSpace;
            neg_d   = 1'b0;
            acc_d   = '0;
            nlen_d  = '0;
            cmd_d   = CmdUnknown;
            adr_d   = '0;
            val_d   = '0;
          end else begin
            err = 1'b1;
          end
        end
      end
      StDec: begin
        // read ahead one byte a cycle
        if (walk_q != cnt_q) begin
          pv_d   = 1'b1;
          pidx_d = walk_q;
          walk_d = walk_q + 1'b1;
        end
        if (pv_q) begin
          if (hsep_q) begin
            if (b == sep_q) begin
              close = 1'b1;
              tgt   = (cur_q == 2'd3) ? 2'd3 : cur_q + 2'd1;
              fresh = 1'b1;
            end
          end else if (fsel != cur_q) begin
            close = 1'b1;
            tgt   = fsel;
            fresh = 1'b1;
          end
          cur_d = tgt;
          // feed the byte to the target field
          ps_b   = fresh ? PsSpace : ps_q;
          neg_b  = fresh ? 1'b0 : neg_q;
          acc_b  = fresh ? 32'd0 : acc_q;
          nlen_b = fresh ? 3'd0 : nlen_q;
          ps_d   = ps_b;
          neg_d  = neg_b;
          acc_d  = acc_b;
          nlen_d = nlen_b;
          if (!(hsep_q && b == sep_q)) begin
            if (tgt == 2'd0) begin
              if (nlen_b == 3'd0) nc0_d = b;
              if (nlen_b == 3'd1) nc1_d = b;
              if (nlen_b == 3'd2) nc2_d = b;
              if (nlen_b != 3'd4) nlen_d = nlen_b + 3'd1;
            end else if (tgt != 2'd3) begin
              unique case (ps_b)
                PsSpace: begin
                  if (b == ChSpace || (b >= ChTab && b <= ChCr)) begin
                    ps_d = PsSpace;
                  end else if (b == ChPlus || b == ChMinus) begin
                    neg_d = (b == ChMinus);
                    ps_d  = PsDigit;
                  end else if (is_dig(b)) begin
                    acc_d = {28'd0, b[3:0]};
                    ps_d  = PsDigit;
                  end else begin
                    ps_d = PsDone;
                  end
                end
                PsDigit: begin
                  if (is_dig(b)) acc_d = (acc_b << 3) + (acc_b << 1) + {28'd0, b[3:0]};
                  else ps_d = PsDone;
                end
                default: ps_d = PsDone;
              endcase
            end
          end
          if (close) begin
            if (cur_q == 2'd0) cmd_d = nm;
            if (cur_q == 2'd1) adr_d = pres;
            if (cur_q == 2'd2) val_d = pres;
          end
        end else if (walk_q == cnt_q && out_free) begin
          // close the last field and emit
          mv_d    = 1'b1;
          oc_d    = (cur_q == 2'd0) ? nm : cmd_q;
          oa_d    = (cur_q == 2'd1) ? pres : adr_q;
          ov_d    = (cur_q == 2'd2) ? pres : val_q;
          os_d    = (hsep_q ? (cur_q != 2'd0) : (kk != cnt_q)) ? StatOk : StatFields;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // framing error result
    if (err) begin
      mv_d    = 1'b1;
      os_d    = StatFrame;
      oc_d    = CmdUnknown;
      oa_d    = '0;
      ov_d    = '0;
      state_d = StIdle;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      mv_q     <= 1'b0;
      pv_q     <= 1'b0;
      start_q  <= StartCharRst;
      end_q    <= EndCharRst;
      sep_q    <= SepCharRst;
      minpay_q <= MinPayRst;
      adig_q   <= AddrDigRst;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
      pv_q    <= pv_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegStartChar: start_q  <= cfg_wdata_i;
          RegEndChar:   end_q    <= cfg_wdata_i;
          RegSepChar:   sep_q    <= cfg_wdata_i;
          RegMinPay:    minpay_q <= cfg_wdata_i[5:0];
          RegAddrDig:   adig_q   <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // decode datapath registers
  always_ff @(posedge clk_i) begin
    hsep_q   <= hsep_d;
    dfound_q <= dfound_d;
    dpos_q   <= dpos_d;
    walk_q   <= walk_d;
    pidx_q   <= pidx_d;
    cur_q    <= cur_d;
    ps_q     <= ps_d;
    neg_q    <= neg_d;
    acc_q    <= acc_d;
    nlen_q   <= nlen_d;
    nc0_q    <= nc0_d;
    nc1_q    <= nc1_d;
    nc2_q    <= nc2_d;
    cmd_q    <= cmd_d;
    adr_q    <= adr_d;
    val_q    <= val_d;
    os_q     <= os_d;
    oc_q     <= oc_d;
    oa_q     <= oa_d;
    ov_q     <= ov_d;
  end

endmodule
`default_nettype wire

/* rtl/core/acfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module acfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
